// File: sv/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

	// 6k +/- 1 wheel
	localparam int FIRST_DIVISOR = 5;
	localparam int WHEEL_STEP    = 6;
	localparam int PAIR_OFFSET   = 2;
	localparam int SMALL_PRIME   = 3;

	// divider handshake back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// File: sv/tdpt_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module tdpt_divider
	import tdpt_pkg::*;
#(
	parameter int NUM_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_WIDTH-1:0] dividend,
	input  wire logic [NUM_WIDTH-1:0] divisor,
	output div_status_t               status,
	output logic      [NUM_WIDTH-1:0] quotient,
	output logic      [NUM_WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(NUM_WIDTH);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_WIDTH:0]   rem_q;
	logic [NUM_WIDTH-1:0] quo_q;
	logic [NUM_WIDTH-1:0] div_q;

	logic [NUM_WIDTH:0]   shifted;
	logic [NUM_WIDTH:0]   diff;

	// one restoring step per cycle
	assign shifted = {rem_q[NUM_WIDTH-1:0], quo_q[NUM_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (diff[NUM_WIDTH]) begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_WIDTH-2:0], 1'b0};
			end else begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_WIDTH-2:0], 1'b1};
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q[NUM_WIDTH-1:0];

endmodule

`default_nettype wire

// File: sv/trial_division_prime_test_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata fields (lsb first)     tuser  tlast
// s_axis    in   candidate[NUM_WIDTH-1:0]     -      -
// m_axis    out  is_prime[0]                  -      -
//
// small, even and negative candidates are settled in S_CHECK and answer without the divider.
// n mod 3 is a base-4 digit sum, two bits per cycle, so multiples of 3 also answer
// without the divider. each wheel divisor then runs through one shared restoring
// divider, one remainder at a time; a prime tries both 6k-1 and 6k+1 of each wheel
// step until d*d > n, and the test stops at the first divisor with no remainder.
// s_axis_tready is high only while no candidate is in work.
// arst_n clears the sequencer and the output valid; a stalled result holds its beat.

module trial_division_prime_test_core
	import tdpt_pkg::*;
#(
	parameter int NUM_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [((NUM_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // candidate
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [7:0]                               m_axis_tdata   // is_prime
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MOD3,
		S_DIV_LO,
		S_DIV_HI,
		S_PUSH
	} state_t;

	state_t               state_q;
	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic [NUM_WIDTH-1:0] dv_q;
	logic [NUM_WIDTH-1:0] sh_q;
	logic [1:0]           r3_q;
	logic                 start_q;
	logic                 pend_q;
	logic                 out_valid_q;
	logic                 out_bit_q;

	div_status_t          div_st;
	logic [NUM_WIDTH-1:0] quo;
	logic [NUM_WIDTH-1:0] rem;
	logic [NUM_WIDTH-1:0] d_next;
	logic [2:0]           r3_sum;
	logic [1:0]           r3_next;

	assign d_next = d_q + NUM_WIDTH'(WHEEL_STEP);

	// running residue plus the next base-4 digit, folded back below 3
	assign r3_sum  = {1'b0, r3_q} + {1'b0, sh_q[1:0]};
	assign r3_next = (r3_sum >= 3'(SMALL_PRIME)) ? 2'(r3_sum - 3'(SMALL_PRIME)) : r3_sum[1:0];

	tdpt_divider #(
		.NUM_WIDTH(NUM_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (dv_q),
		.status   (div_st),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
			n_q         <= '0;
			d_q         <= '0;
			dv_q        <= '0;
			sh_q        <= '0;
			r3_q        <= '0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						n_q     <= s_axis_tdata[NUM_WIDTH-1:0];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (n_q[NUM_WIDTH-1] || n_q <= NUM_WIDTH'(1)) begin
						pend_q  <= 1'b0;
						state_q <= S_PUSH;
					end else if (n_q <= NUM_WIDTH'(SMALL_PRIME)) begin
						pend_q  <= 1'b1;
						state_q <= S_PUSH;
					end else if (!n_q[0]) begin
						pend_q  <= 1'b0;
						state_q <= S_PUSH;
					end else begin
						sh_q    <= n_q;
						r3_q    <= '0;
						state_q <= S_MOD3;
					end
				end
				S_MOD3: begin
					// 4 is 1 mod 3, so the base-4 digit sum keeps the residue
					if (sh_q == '0) begin
						if (r3_q == '0) begin
							pend_q  <= 1'b0;
							state_q <= S_PUSH;
						end else begin
							d_q     <= NUM_WIDTH'(FIRST_DIVISOR);
							dv_q    <= NUM_WIDTH'(FIRST_DIVISOR);
							start_q <= 1'b1;
							state_q <= S_DIV_LO;
						end
					end else begin
						sh_q <= sh_q >> 2;
						r3_q <= r3_next;
					end
				end
				S_DIV_LO: begin
					if (div_st.done) begin
						// d > n / d means d*d > n: no divisor left
						if (d_q > quo) begin
							pend_q  <= 1'b1;
							state_q <= S_PUSH;
						end else if (rem == '0) begin
							pend_q  <= 1'b0;
							state_q <= S_PUSH;
						end else begin
							dv_q    <= d_q + NUM_WIDTH'(PAIR_OFFSET);
							start_q <= 1'b1;
							state_q <= S_DIV_HI;
						end
					end
				end
				S_DIV_HI: begin
					if (div_st.done) begin
						if (rem == '0) begin
							pend_q  <= 1'b0;
							state_q <= S_PUSH;
						end else begin
							d_q     <= d_next;
							dv_q    <= d_next;
							start_q <= 1'b1;
							state_q <= S_DIV_LO;
						end
					end
				end
				S_PUSH: begin
					// wait for the output beat slot to free up
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_bit_q   <= pend_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE) && !div_st.busy;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_bit_q};

endmodule

`default_nettype wire
